@@ hdl/skvt_pkg.sv @@
// shared types and constants for the sorted key/value table
// no dependencies; used by skvt_ctrl, skvt_dp and sorted_key_value_table

package skvt_pkg;

   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 64;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_READOUT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_SUCCESS   = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_DUPLICATE = 2'd2
   } status_type;

   typedef struct packed {
      logic                 operation;
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic                 row_valid;
      logic [KEY_W-1:0]     row_key;
      logic [PAYLOAD_W-1:0] row_payload;
      logic                 last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic insert;
      logic start_read;
      logic rotate;
      logic emit_empty;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_read;
      logic count_zero;
      logic row_last;
      logic slot_free;
   } dp_status_type;

endpackage

@@ hdl/skvt_ctrl.sv @@
// sequencer for the sorted key/value table: accept, execute, readout
// depends on skvt_pkg

module skvt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  skvt_pkg::dp_status_type status,
   output skvt_pkg::dp_cmd_type   cmd
);

   skvt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skvt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         skvt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = skvt_pkg::ST_EXEC;
            end
         end
         skvt_pkg::ST_EXEC: begin
            if (status.slot_free) begin
               if (!status.op_read || status.count_zero) begin
                  state_in = skvt_pkg::ST_IDLE;
               end else begin
                  state_in = skvt_pkg::ST_READ;
               end
            end
         end
         skvt_pkg::ST_READ: begin
            if (status.slot_free && status.row_last) begin
               state_in = skvt_pkg::ST_IDLE;
            end
         end
         default: state_in = skvt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         skvt_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         skvt_pkg::ST_EXEC: begin
            if (status.slot_free) begin
               cmd.insert     = !status.op_read;
               cmd.emit_empty = status.op_read && status.count_zero;
               cmd.start_read = status.op_read && !status.count_zero;
            end
         end
         skvt_pkg::ST_READ: begin
            cmd.rotate = status.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/skvt_dp.sv @@
// datapath: request register, sorted entry cells, entry count and response register
// depends on skvt_pkg; driven by skvt_ctrl commands

module skvt_dp #(
   parameter int CAPACITY = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  skvt_pkg::req_type       req_item,
   input  skvt_pkg::dp_cmd_type    cmd,
   output skvt_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output skvt_pkg::rsp_type       rsp_item
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   skvt_pkg::req_type req_ff;

   logic [skvt_pkg::KEY_W-1:0]     keys_ff     [CAPACITY];
   logic [skvt_pkg::KEY_W-1:0]     keys_in     [CAPACITY];
   logic [skvt_pkg::PAYLOAD_W-1:0] payloads_ff [CAPACITY];
   logic [skvt_pkg::PAYLOAD_W-1:0] payloads_in [CAPACITY];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] remaining_ff, remaining_in;

   logic              rsp_valid_ff, rsp_valid_in;
   skvt_pkg::rsp_type rsp_ff, rsp_in;

   logic [CAPACITY-1:0] big;
   logic [CAPACITY-1:0] hit;
   logic                dup;
   logic                full;
   logic                wr_ok;
   logic                slot_free;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_item;
      end
   end

   // parallel compare against every stored key
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
      assign big[i] = (CNT_W'(i) < count_ff) && (keys_ff[i] > req_ff.key);
      assign hit[i] = (CNT_W'(i) < count_ff) && (keys_ff[i] == req_ff.key);
   end

   assign dup   = |hit;
   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign wr_ok = cmd.insert && !dup && !full;

   // each cell: open a gap and shift up on insert, rotate down on readout
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic in_region;
      logic from_below;
      logic at_top;
      logic [skvt_pkg::KEY_W-1:0]     up_key;
      logic [skvt_pkg::PAYLOAD_W-1:0] up_payload;

      assign in_region = big[i] || (CNT_W'(i) == count_ff);
      assign at_top    = (CNT_W'(i + 1) == count_ff);

      if (i == 0) begin : g_bottom
         assign from_below = 1'b0;
      end else begin : g_upper
         assign from_below = big[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign up_key     = keys_ff[0];
         assign up_payload = payloads_ff[0];
      end else begin : g_mid
         assign up_key     = keys_ff[i+1];
         assign up_payload = payloads_ff[i+1];
      end

      always_comb begin
         keys_in[i]     = keys_ff[i];
         payloads_in[i] = payloads_ff[i];
         if (wr_ok && in_region) begin
            if (from_below) begin
               keys_in[i]     = keys_ff[(i == 0) ? 0 : i - 1];
               payloads_in[i] = payloads_ff[(i == 0) ? 0 : i - 1];
            end else begin
               keys_in[i]     = req_ff.key;
               payloads_in[i] = req_ff.payload;
            end
         end else if (cmd.rotate && (CNT_W'(i) < count_ff)) begin
            if (at_top) begin
               keys_in[i]     = keys_ff[0];
               payloads_in[i] = payloads_ff[0];
            end else begin
               keys_in[i]     = up_key;
               payloads_in[i] = up_payload;
            end
         end
      end

      always_ff @(posedge clock) begin
         keys_ff[i]     <= keys_in[i];
         payloads_ff[i] <= payloads_in[i];
      end
   end

   always_comb begin
      count_in     = count_ff;
      remaining_in = remaining_ff;
      if (wr_ok) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.start_read) begin
         remaining_in = count_ff;
      end else if (cmd.rotate) begin
         remaining_in = remaining_ff - CNT_W'(1);
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (cmd.insert) begin
         rsp_valid_in       = 1'b1;
         rsp_in             = '0;
         rsp_in.last        = 1'b1;
         if (dup) begin
            rsp_in.status = skvt_pkg::STATUS_DUPLICATE;
         end else if (full) begin
            rsp_in.status = skvt_pkg::STATUS_FULL;
         end else begin
            rsp_in.status = skvt_pkg::STATUS_SUCCESS;
         end
      end else if (cmd.emit_empty) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = '0;
         rsp_in.status = skvt_pkg::STATUS_SUCCESS;
         rsp_in.last   = 1'b1;
      end else if (cmd.rotate) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = skvt_pkg::STATUS_SUCCESS;
         rsp_in.row_valid   = 1'b1;
         rsp_in.row_key     = keys_ff[0];
         rsp_in.row_payload = payloads_ff[0];
         rsp_in.last        = (remaining_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign status.op_read    = (req_ff.operation == skvt_pkg::OP_READOUT);
   assign status.count_zero = (count_ff == '0);
   assign status.row_last   = (remaining_ff == CNT_W'(1));
   assign status.slot_free  = slot_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_rotate_rows_left: assert property (@(posedge clock) disable iff (reset)
      cmd.rotate |-> (remaining_ff != '0))
      else $error("readout rotation with no rows left");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.insert, cmd.emit_empty, cmd.rotate, cmd.start_read}))
      else $error("conflicting datapath commands");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      wr_ok |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("successful insert did not grow the table");
`endif

endmodule

@@ hdl/sorted_key_value_table.sv @@
// Sorted key/value table of CAPACITY entries (32-bit key, 64-bit payload) kept in ascending
// key order. An insert first registers the transaction, then compares every stored key at once
// and shifts the entries above the new key up a place; it answers duplicate, full or success
// in one response. A readout registers the transaction, then gives one response with no row
// when empty, or else the entry cells rotate one place per cycle while the response register
// is free, so one row per cycle leaves through the single response register, the last one
// marked. Backpressure on the response side stalls both operations. The next request
// is taken as soon as the final response of the current one is loaded into the response
// register. The entry cells need no clearing after reset.
// depends on skvt_pkg, skvt_ctrl and skvt_dp

module sorted_key_value_table #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  skvt_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output skvt_pkg::rsp_type rsp_item
);

   skvt_pkg::dp_cmd_type    cmd;
   skvt_pkg::dp_status_type status;

   skvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   skvt_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
